FILE: sv/multi_channel_soft_timer_bank_top_defines.svh
// ---------------------------------------------------------------------------
// Timer bank assertion macros
// Concurrent assertion wrappers, empty under synthesis.
// ---------------------------------------------------------------------------
`ifndef MULTI_CHANNEL_SOFT_TIMER_BANK_TOP_DEFINES_SVH
`define MULTI_CHANNEL_SOFT_TIMER_BANK_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define MCTB_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("mctb assertion failed");
`define MCTB_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("mctb assertion failed");
`else
`define MCTB_ASSERT(lbl, clk, rst_n, prop)
`define MCTB_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

FILE: sv/mctb_pkg.sv
// ---------------------------------------------------------------------------
// Timer bank package
// Shared types, constants and wrap-safe time compare.
// ---------------------------------------------------------------------------
`default_nettype none

package mctb_pkg;

  localparam int NUM_CHANNELS = 16;
  localparam int ChW          = 6;
  localparam int TimeW        = 32;
  localparam int ChIdxW       = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  typedef enum logic [1:0] {
    CMD_REGISTER = 2'd0,
    CMD_START    = 2'd1,
    CMD_STOP     = 2'd2,
    CMD_TICK     = 2'd3
  } mctb_cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SUMM
  } mctb_state_e;

  typedef struct packed {
    logic exec;
    logic tick_start;
    logic scan;
    logic summ;
  } mctb_ctl_t;

  typedef struct packed {
    logic is_tick;
    logic scan_last;
  } mctb_sts_t;

  // a has reached b when (a - b) mod 2^32 is below 2^31
  function automatic logic reached(logic [TimeW-1:0] a, logic [TimeW-1:0] b);
    logic [TimeW-1:0] diff;
    diff = a - b;
    return ~diff[TimeW-1];
  endfunction

endpackage

`default_nettype wire

FILE: sv/multi_channel_soft_timer_bank_top.sv
// Register, start and stop: accepted while idle, result in the next cycle, no busy.
// Tick: busy for the scan, one channel per cycle, and for the deadline commit.
// Fired results follow the scan one per cycle; the summary comes last.
// The receiver cannot stall. Asynchronous active-low reset clears tick count,
// deadline, registered and armed flags; channel tables hold until written.
// ---------------------------------------------------------------------------
// Timer bank top level
// Bank of periodic and one-shot timer channels with a tick-driven scan.
// ---------------------------------------------------------------------------
`default_nettype none

`include "multi_channel_soft_timer_bank_top_defines.svh"

module multi_channel_soft_timer_bank_top
  import mctb_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start,
  output logic                  busy,
  input  wire logic [1:0]       cmd_i,
  input  wire logic [ChW-1:0]   channel_i,
  input  wire logic [TimeW-1:0] period_i,
  input  wire logic             repeat_req_i,
  output logic                  result_valid_o,
  output logic                  status_o,
  output logic                  fired_o,
  output logic [ChW-1:0]        fired_channel_o,
  output logic [TimeW-1:0]      earliest_deadline_o,
  output logic                  any_armed_o,
  output logic                  last_o
);

  mctb_ctl_t ctl;
  mctb_sts_t sts;

  mctb_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .sts_i  (sts),
    .busy   (busy),
    .ctl_o  (ctl)
  );

  mctb_datapath u_datapath (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .ctl_i               (ctl),
    .sts_o               (sts),
    .cmd_i               (cmd_i),
    .channel_i           (channel_i),
    .period_i            (period_i),
    .repeat_req_i        (repeat_req_i),
    .result_valid_o      (result_valid_o),
    .status_o            (status_o),
    .fired_o             (fired_o),
    .fired_channel_o     (fired_channel_o),
    .earliest_deadline_o (earliest_deadline_o),
    .any_armed_o         (any_armed_o),
    .last_o              (last_o)
  );

  `MCTB_ASSERT_ALWAYS(a_fired_not_last, clk_i, (result_valid_o && fired_o) |-> (!last_o && !status_o))
  `MCTB_ASSERT(a_cmd_single_result, clk_i, rst_ni, (start && !busy && cmd_i != CMD_TICK) |=> (result_valid_o && last_o))
  `MCTB_ASSERT(a_tick_ends_summary, clk_i, rst_ni, $fell(busy) |-> (result_valid_o && last_o && !fired_o))

endmodule

`default_nettype wire

FILE: sv/mctb_ctrl.sv
// ---------------------------------------------------------------------------
// Timer bank controller
// Sequences register, start and stop commands and the per-channel tick scan.
// ---------------------------------------------------------------------------
`default_nettype none

module mctb_ctrl
  import mctb_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      start,
  input  wire mctb_sts_t sts_i,
  output logic           busy,
  output mctb_ctl_t      ctl_o
);

  mctb_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    ctl_o   = '0;
    busy    = 1'b1;
    case (state_q)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          if (sts_i.is_tick) begin
            ctl_o.tick_start = 1'b1;
            state_d          = ST_SCAN;
          end else begin
            ctl_o.exec = 1'b1;
          end
        end
      end
      ST_SCAN: begin
        ctl_o.scan = 1'b1;
        if (sts_i.scan_last) begin
          state_d = ST_SUMM;
        end
      end
      ST_SUMM: begin
        ctl_o.summ = 1'b1;
        state_d    = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: sv/mctb_datapath.sv
// ---------------------------------------------------------------------------
// Timer bank datapath
// Channel tables, tick counter, deadline tracking and result register.
// ---------------------------------------------------------------------------
`default_nettype none

module mctb_datapath
  import mctb_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire mctb_ctl_t        ctl_i,
  output mctb_sts_t             sts_o,
  input  wire logic [1:0]       cmd_i,
  input  wire logic [ChW-1:0]   channel_i,
  input  wire logic [TimeW-1:0] period_i,
  input  wire logic             repeat_req_i,
  output logic                  result_valid_o,
  output logic                  status_o,
  output logic                  fired_o,
  output logic [ChW-1:0]        fired_channel_o,
  output logic [TimeW-1:0]      earliest_deadline_o,
  output logic                  any_armed_o,
  output logic                  last_o
);

  logic [TimeW-1:0] period_q [NUM_CHANNELS];
  logic [TimeW-1:0] expiry_q [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] periodic_q;

  logic [NUM_CHANNELS-1:0] registered_q, registered_d;
  logic [NUM_CHANNELS-1:0] armed_q, armed_d;
  logic [TimeW-1:0]        tick_q, tick_d;
  logic [TimeW-1:0]        next_dl_q, next_dl_d;
  logic [ChIdxW-1:0]       scan_q, scan_d;
  logic [TimeW-1:0]        cand_q, cand_d;
  logic                    found_q, found_d;

  logic           valid_q, valid_d;
  logic           status_q, status_d;
  logic           fired_q, fired_d;
  logic [ChW-1:0] fchan_q, fchan_d;
  logic           last_q, last_d;

  logic              ch_ok;
  logic [ChIdxW-1:0] ch_idx, rd_idx;
  logic [TimeW-1:0]  rd_period, rd_exp, sum;
  logic              rd_periodic;
  logic              per_we, exp_we;
  logic [TimeW-1:0]  exp_wdata;
  logic              hit, keep;
  logic [TimeW-1:0]  exp_after;

  assign ch_ok       = channel_i < ChW'(NUM_CHANNELS);
  assign ch_idx      = channel_i[ChIdxW-1:0];
  assign rd_idx      = ctl_i.scan ? scan_q : ch_idx;
  assign rd_period   = period_q[rd_idx];
  assign rd_exp      = expiry_q[rd_idx];
  assign rd_periodic = periodic_q[rd_idx];
  assign sum         = tick_q + rd_period;

  assign hit       = armed_q[scan_q] & reached(tick_q, rd_exp);
  assign keep      = armed_q[scan_q] & ~(hit & ~rd_periodic);
  assign exp_after = (hit && rd_periodic) ? sum : rd_exp;

  assign sts_o.is_tick   = (mctb_cmd_e'(cmd_i) == CMD_TICK);
  assign sts_o.scan_last = (scan_q == ChIdxW'(NUM_CHANNELS - 1));

  always_comb begin
    registered_d = registered_q;
    armed_d      = armed_q;
    tick_d       = tick_q;
    next_dl_d    = next_dl_q;
    scan_d       = scan_q;
    cand_d       = cand_q;
    found_d      = found_q;
    valid_d      = 1'b0;
    status_d     = 1'b0;
    fired_d      = 1'b0;
    fchan_d      = '0;
    last_d       = 1'b0;
    per_we       = 1'b0;
    exp_we       = 1'b0;
    exp_wdata    = sum;

    if (ctl_i.exec) begin
      valid_d = 1'b1;
      last_d  = 1'b1;
      case (mctb_cmd_e'(cmd_i))
        CMD_REGISTER: begin
          if (!ch_ok || period_i == '0 || registered_q[ch_idx]) begin
            status_d = 1'b1;
          end else begin
            registered_d[ch_idx] = 1'b1;
            per_we               = 1'b1;
            exp_we               = 1'b1;
            exp_wdata            = '0;
          end
        end
        CMD_START: begin
          if (!ch_ok || !registered_q[ch_idx]) begin
            status_d = 1'b1;
          end else begin
            exp_we          = 1'b1;
            armed_d[ch_idx] = 1'b1;
            if (!(|armed_q) || reached(next_dl_q, sum)) begin
              next_dl_d = sum;
            end
          end
        end
        CMD_STOP: begin
          if (!ch_ok || !registered_q[ch_idx]) begin
            status_d = 1'b1;
          end else begin
            armed_d[ch_idx] = 1'b0;
          end
        end
        default: begin
          valid_d = 1'b0;
          last_d  = 1'b0;
        end
      endcase
    end

    if (ctl_i.tick_start) begin
      tick_d  = tick_q + 1'b1;
      scan_d  = '0;
      found_d = 1'b0;
    end

    if (ctl_i.scan) begin
      scan_d = scan_q + 1'b1;
      if (hit) begin
        if (rd_periodic) begin
          exp_we = 1'b1;
        end else begin
          armed_d[scan_q] = 1'b0;
        end
        valid_d = 1'b1;
        fired_d = 1'b1;
        fchan_d = ChW'(scan_q);
      end
      if (keep && (!found_q || reached(cand_q, exp_after))) begin
        cand_d  = exp_after;
        found_d = 1'b1;
      end
    end

    if (ctl_i.summ) begin
      if (found_q) begin
        next_dl_d = cand_q;
      end
      valid_d = 1'b1;
      last_d  = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      registered_q <= '0;
      armed_q      <= '0;
      tick_q       <= '0;
      next_dl_q    <= '0;
      scan_q       <= '0;
      found_q      <= 1'b0;
      valid_q      <= 1'b0;
    end else begin
      registered_q <= registered_d;
      armed_q      <= armed_d;
      tick_q       <= tick_d;
      next_dl_q    <= next_dl_d;
      scan_q       <= scan_d;
      found_q      <= found_d;
      valid_q      <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cand_q   <= cand_d;
    status_q <= status_d;
    fired_q  <= fired_d;
    fchan_q  <= fchan_d;
    last_q   <= last_d;
    if (per_we) begin
      period_q[rd_idx]   <= period_i;
      periodic_q[rd_idx] <= repeat_req_i;
    end
    if (exp_we) begin
      expiry_q[rd_idx] <= exp_wdata;
    end
  end

  assign result_valid_o      = valid_q;
  assign status_o            = status_q;
  assign fired_o             = fired_q;
  assign fired_channel_o     = fchan_q;
  assign last_o              = last_q;
  assign earliest_deadline_o = next_dl_q;
  assign any_armed_o         = |armed_q;

endmodule

`default_nettype wire
